FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property on the block clock, off while reset is low
`define CHK_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen on the block clock
`define CHK_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: hdl/mp2a_pkg.sv
`default_nettype none

package mp2a_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_WINDOW   = 8;
    localparam int SAMPLE_BITS  = 16;
    localparam int HEIGHT_LIMIT = 1024;

    // register field widths
    localparam int WS_REG_W   = 4;
    localparam int STEP_REG_W = 4;
    localparam int DIM_REG_W  = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    // result field widths
    localparam int ARG_W     = 6;
    localparam int OUT_POS_W = 10;

    // internal widths
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int CNTC_W      = $clog2(MAX_WIDTH + 16);
    localparam int CSUM_W      = CNTC_W + 1;
    localparam int ROW_W       = $clog2(HEIGHT_LIMIT);
    localparam int ROWN_W      = $clog2(HEIGHT_LIMIT + 16);
    localparam int RSUM_W      = ROWN_W + 1;
    localparam int WIN_W       = $clog2(MAX_WINDOW + 1);
    localparam int SLOT_W      = $clog2(MAX_WINDOW);
    localparam int SLOT_SUM_W  = $clog2(2 * MAX_WINDOW);
    localparam int IDX_W       = $clog2(MAX_WINDOW * MAX_WINDOW);
    localparam int RAM_DEPTH   = MAX_WINDOW * MAX_WIDTH;
    localparam int ADDR_W      = $clog2(RAM_DEPTH);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW = 2'd0,
        REG_STEP   = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic clear;
        logic take;
    } cmp_ctl_t;

    function automatic logic [WIN_W-1:0] eff_ws(input logic [WS_REG_W-1:0] v);
        logic [WIN_W-1:0] r;
        if (v == '0)
            r = WIN_W'(1);
        else if (int'(v) > MAX_WINDOW)
            r = WIN_W'(MAX_WINDOW);
        else
            r = WIN_W'(v);
        return r;
    endfunction

    function automatic logic [STEP_REG_W-1:0] eff_step(input logic [STEP_REG_W-1:0] v);
        return (v == '0) ? STEP_REG_W'(1) : v;
    endfunction

    function automatic logic [CNTC_W-1:0] eff_w(input logic [DIM_REG_W-1:0] v);
        logic [CNTC_W-1:0] r;
        if (v == '0)
            r = CNTC_W'(1);
        else if (int'(v) > MAX_WIDTH)
            r = CNTC_W'(MAX_WIDTH);
        else
            r = CNTC_W'(v);
        return r;
    endfunction

    function automatic logic [ROWN_W-1:0] eff_h(input logic [DIM_REG_W-1:0] v);
        logic [ROWN_W-1:0] r;
        if (v == '0)
            r = ROWN_W'(1);
        else if (int'(v) > HEIGHT_LIMIT)
            r = ROWN_W'(HEIGHT_LIMIT);
        else
            r = ROWN_W'(v);
        return r;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(MAX_WINDOW - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] ram_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [COL_W-1:0] c);
        return ADDR_W'(s) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/mp2a_if.sv
`default_nettype none

interface mp2a_pixel_if;
    logic                 valid;
    logic                 ready;
    mp2a_pkg::sample_t    sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mp2a_result_if;
    logic                               valid;
    logic                               ready;
    mp2a_pkg::sample_t                  max_value;
    logic [mp2a_pkg::ARG_W-1:0]         argmax_index;
    logic [mp2a_pkg::OUT_POS_W-1:0]     out_row;
    logic [mp2a_pkg::OUT_POS_W-1:0]     out_col;
    logic                               plane_done;

    modport source (output valid, output max_value, output argmax_index, output out_row,
                    output out_col, output plane_done, input ready);
    modport sink   (input valid, input max_value, input argmax_index, input out_row,
                    input out_col, input plane_done, output ready);
endinterface

interface mp2a_cfg_if;
    logic                               valid;
    logic                               ready;
    mp2a_pkg::reg_idx_t                 index;
    logic [mp2a_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/mp2a_ram.sv
`default_nettype none

module mp2a_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: hdl/mp2a_cmp.sv
`default_nettype none

module mp2a_cmp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mp2a_pkg::cmp_ctl_t           ctl,
    input  mp2a_pkg::sample_t            value,
    input  logic [mp2a_pkg::IDX_W-1:0]   idx,
    output mp2a_pkg::sample_t            best,
    output logic [mp2a_pkg::IDX_W-1:0]   best_idx
);
    import mp2a_pkg::*;

    logic    first_reg;
    sample_t best_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic    upd;

    // strict greater-than keeps the earliest maximum on ties
    assign upd = ctl.take && (first_reg || (value > best_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
        end
        else if (ctl.clear)
        begin
            first_reg <= 1'b1;
        end
        else if (ctl.take)
        begin
            first_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            best_reg     <= value;
            best_idx_reg <= idx;
        end
    end

    assign best     = best_reg;
    assign best_idx = best_idx_reg;

endmodule

`default_nettype wire

FILE: hdl/max_pool_2d_argmax.sv
// a sample that completes no window is taken without leaving the idle state
// a sample that completes a window starts a scan of the window: one line store
// read per window sample through a single compare unit, then flush and result load
// read data goes via the compare register into the result; new samples wait for the load
// reset (async, active low) sets registers to 2, 2, 28, 28 and the plane position to start;
// line store contents are not cleared
`default_nettype none

`include "assert_macros.svh"

module max_pool_2d_argmax (
    input  logic               clk,
    input  logic               rst_n,
    mp2a_pixel_if.sink         pixel,
    mp2a_result_if.source      result,
    mp2a_cfg_if.sink           cfg
);
    import mp2a_pkg::*;

    typedef enum logic [1:0] {IDLE, SCAN, FLUSH, DONE} state_t;

    state_t state_reg;

    // configuration
    logic [WS_REG_W-1:0]   ws_reg;
    logic [STEP_REG_W-1:0] step_reg;
    logic [DIM_REG_W-1:0]  width_reg;
    logic [DIM_REG_W-1:0]  height_reg;

    logic [WIN_W-1:0]      ws_eff;
    logic [WIN_W-1:0]      ws_m1;
    logic [STEP_REG_W-1:0] st_eff;
    logic [CNTC_W-1:0]     w_eff;
    logic [ROWN_W-1:0]     h_eff;

    // plane position
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [ROWN_W-1:0]    nwr_reg, nwr_next;
    logic [CNTC_W-1:0]    nwc_reg, nwc_next;
    logic [OUT_POS_W-1:0] orow_reg, orow_next;
    logic [COL_W-1:0]     ocol_reg, ocol_next;

    // window scan
    logic [WIN_W-1:0]  ph_reg;
    logic [WIN_W-1:0]  pw_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [SLOT_W-1:0] rslot_reg;
    logic [COL_W-1:0]  c0_reg;
    logic [COL_W-1:0]  rcol_reg;
    logic              cmp_vld_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;

    // result register
    logic               out_vld_reg;
    sample_t            out_val_reg;
    logic [ARG_W-1:0]   out_arg_reg;
    logic [OUT_POS_W-1:0] out_row_reg;
    logic [OUT_POS_W-1:0] out_col_reg;
    logic               out_last_reg;

    logic cfg_take, pix_take, hit, out_free, load_out, advance, adv_hit;
    logic col_end, row_end, row_on_win, restart, win_last;
    logic [WIN_W-1:0] ws_rst;
    logic [COL_W-1:0] c0;
    logic [SLOT_SUM_W-1:0] slot_sum;
    logic [SLOT_W-1:0] slot_start;
    logic [SAMPLE_BITS-1:0] rd_data;
    sample_t best;
    logic [IDX_W-1:0] best_idx;
    cmp_ctl_t cmp_ctl;

    assign ws_eff = eff_ws(ws_reg);
    assign ws_m1  = ws_eff - WIN_W'(1);
    assign st_eff = eff_step(step_reg);
    assign w_eff  = eff_w(width_reg);
    assign h_eff  = eff_h(height_reg);

    assign cfg.ready   = (state_reg == IDLE);
    assign pixel.ready = (state_reg == IDLE) && !cfg.valid;
    assign cfg_take    = cfg.valid && cfg.ready;
    assign pix_take    = pixel.valid && pixel.ready;

    assign hit = (ROWN_W'(row_reg) == nwr_reg) && (CNTC_W'(col_reg) == nwc_reg);

    assign out_free = !out_vld_reg || result.ready;
    assign load_out = (state_reg == DONE) && out_free;
    assign adv_hit  = (state_reg == DONE);
    assign advance  = (pix_take && !hit) || load_out;

    assign col_end    = (CNTC_W'(col_reg) + CNTC_W'(1)) >= w_eff;
    assign row_end    = (ROWN_W'(row_reg) + ROWN_W'(1)) >= h_eff;
    assign row_on_win = (ROWN_W'(row_reg) == nwr_reg);
    assign restart    = cfg_take || (advance && col_end && row_end);
    assign ws_rst     = (cfg_take && (cfg.index == REG_WINDOW)) ?
                        eff_ws(cfg.data[WS_REG_W-1:0]) : ws_eff;

    assign win_last = ((CSUM_W'(nwc_reg) + CSUM_W'(st_eff)) >= CSUM_W'(w_eff)) &&
                      ((RSUM_W'(nwr_reg) + RSUM_W'(st_eff)) >= RSUM_W'(h_eff));

    // leftmost column and oldest line store slot of the window
    assign c0         = COL_W'(CNTC_W'(col_reg) + CNTC_W'(1) - CNTC_W'(ws_eff));
    assign slot_sum   = SLOT_SUM_W'(slot_reg) + SLOT_SUM_W'(MAX_WINDOW) - SLOT_SUM_W'(ws_m1);
    assign slot_start = (slot_sum >= SLOT_SUM_W'(MAX_WINDOW)) ?
                        SLOT_W'(slot_sum - SLOT_SUM_W'(MAX_WINDOW)) : SLOT_W'(slot_sum);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        nwr_next  = nwr_reg;
        nwc_next  = nwc_reg;
        orow_next = orow_reg;
        ocol_next = ocol_reg;
        if (advance)
        begin
            if (adv_hit)
            begin
                nwc_next  = nwc_reg + CNTC_W'(st_eff);
                ocol_next = ocol_reg + COL_W'(1);
            end
            if (col_end)
            begin
                col_next = '0;
                if (row_on_win)
                begin
                    nwr_next  = nwr_reg + ROWN_W'(st_eff);
                    orow_next = orow_reg + OUT_POS_W'(1);
                end
                nwc_next  = CNTC_W'(ws_m1);
                ocol_next = '0;
                row_next  = row_reg + ROW_W'(1);
                slot_next = slot_inc(slot_reg);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
        if (restart)
        begin
            col_next  = '0;
            row_next  = '0;
            slot_next = '0;
            nwr_next  = ROWN_W'(ws_rst - WIN_W'(1));
            nwc_next  = CNTC_W'(ws_rst - WIN_W'(1));
            orow_next = '0;
            ocol_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= IDLE;
            ws_reg      <= WS_REG_W'(2);
            step_reg    <= STEP_REG_W'(2);
            width_reg   <= DIM_REG_W'(28);
            height_reg  <= DIM_REG_W'(28);
            col_reg     <= '0;
            row_reg     <= '0;
            slot_reg    <= '0;
            nwr_reg     <= ROWN_W'(1);
            nwc_reg     <= CNTC_W'(1);
            orow_reg    <= '0;
            ocol_reg    <= '0;
            ph_reg      <= '0;
            pw_reg      <= '0;
            idx_reg     <= '0;
            rslot_reg   <= '0;
            c0_reg      <= '0;
            rcol_reg    <= '0;
            cmp_vld_reg <= 1'b0;
            cmp_idx_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
            nwr_reg  <= nwr_next;
            nwc_reg  <= nwc_next;
            orow_reg <= orow_next;
            ocol_reg <= ocol_next;

            if (cfg_take)
            begin
                case (cfg.index)
                    REG_WINDOW: ws_reg     <= cfg.data[WS_REG_W-1:0];
                    REG_STEP:   step_reg   <= cfg.data[STEP_REG_W-1:0];
                    REG_WIDTH:  width_reg  <= cfg.data[DIM_REG_W-1:0];
                    REG_HEIGHT: height_reg <= cfg.data[DIM_REG_W-1:0];
                    default:    ws_reg     <= ws_reg;
                endcase
            end

            cmp_vld_reg <= (state_reg == SCAN);
            cmp_idx_reg <= idx_reg;

            if (load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end

            case (state_reg)
                IDLE:
                begin
                    if (pix_take && hit)
                    begin
                        ph_reg    <= '0;
                        pw_reg    <= '0;
                        idx_reg   <= '0;
                        rslot_reg <= slot_start;
                        c0_reg    <= c0;
                        rcol_reg  <= c0;
                        state_reg <= SCAN;
                    end
                end
                SCAN:
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (pw_reg == ws_m1)
                    begin
                        pw_reg    <= '0;
                        ph_reg    <= ph_reg + WIN_W'(1);
                        rcol_reg  <= c0_reg;
                        rslot_reg <= slot_inc(rslot_reg);
                        if (ph_reg == ws_m1)
                        begin
                            state_reg <= FLUSH;
                        end
                    end
                    else
                    begin
                        pw_reg   <= pw_reg + WIN_W'(1);
                        rcol_reg <= rcol_reg + COL_W'(1);
                    end
                end
                FLUSH:
                begin
                    state_reg <= DONE;
                end
                DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_val_reg  <= best;
            out_arg_reg  <= ARG_W'(best_idx);
            out_row_reg  <= orow_reg;
            out_col_reg  <= OUT_POS_W'(ocol_reg);
            out_last_reg <= win_last;
        end
    end

    assign cmp_ctl.clear = pix_take && hit;
    assign cmp_ctl.take  = cmp_vld_reg;

    mp2a_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (pix_take),
        .wr_addr (ram_addr(slot_reg, col_reg)),
        .wr_data (pixel.sample),
        .rd_addr (ram_addr(rslot_reg, rcol_reg)),
        .rd_data (rd_data)
    );

    mp2a_cmp u_cmp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (cmp_ctl),
        .value    (sample_t'(rd_data)),
        .idx      (cmp_idx_reg),
        .best     (best),
        .best_idx (best_idx)
    );

    assign result.valid        = out_vld_reg;
    assign result.max_value    = out_val_reg;
    assign result.argmax_index = out_arg_reg;
    assign result.out_row      = out_row_reg;
    assign result.out_col      = out_col_reg;
    assign result.plane_done   = out_last_reg;

    // read data reaches the compare unit in the cycle after its address
    `CHK_PROP(a_cmp_in_scan, cmp_vld_reg |-> (state_reg == SCAN || state_reg == FLUSH), "compare beat outside window scan")
    `CHK_PROP(a_out_from_done, $rose(out_vld_reg) |-> $past(state_reg == DONE), "result loaded outside done state")
    `CHK_PROP(a_scan_bounds, (state_reg == SCAN) |-> (pw_reg < ws_eff && ph_reg < ws_eff), "scan position outside window")
    `CHK_NEVER(a_no_take_busy, pix_take && (state_reg != IDLE), "sample beat taken while scanning")

endmodule

`default_nettype wire

FILE: tb/mp2a_checker.sv
`timescale 1ns / 1ps

module mp2a_checker
    import mp2a_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    mp2a_pixel_if   pix,
    mp2a_result_if  res,
    mp2a_cfg_if     cfg,
    output int      fail_count,
    output int      pending,
    output int      result_count,
    output int      plane_count
);

    typedef struct packed {
        sample_t                max_value;
        logic [ARG_W-1:0]       argmax_index;
        logic [OUT_POS_W-1:0]   out_row;
        logic [OUT_POS_W-1:0]   out_col;
        logic                   plane_done;
    } pool_result_t;

    localparam int PRINT_LIMIT = 40;

    logic [WS_REG_W-1:0]   win_reg;
    logic [STEP_REG_W-1:0] step_reg;
    logic [DIM_REG_W-1:0]  width_reg;
    logic [DIM_REG_W-1:0]  height_reg;

    sample_t line_buf [MAX_WINDOW * MAX_WIDTH];
    int in_col;
    int in_row;
    int buf_slot;
    int corner_row;
    int corner_col;
    int win_row_idx;
    int win_col_idx;

    pool_result_t expected_pool [$];

    function automatic int win_len();
        if (win_reg == '0)
            return 1;
        if (int'(win_reg) > MAX_WINDOW)
            return MAX_WINDOW;
        return int'(win_reg);
    endfunction

    function automatic int stride();
        return (step_reg == '0) ? 1 : int'(step_reg);
    endfunction

    function automatic int row_len();
        if (width_reg == '0)
            return 1;
        if (int'(width_reg) > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int plane_rows();
        if (height_reg == '0)
            return 1;
        if (int'(height_reg) > HEIGHT_LIMIT)
            return HEIGHT_LIMIT;
        return int'(height_reg);
    endfunction

    task automatic start_plane();
        in_col      = 0;
        in_row      = 0;
        buf_slot    = 0;
        corner_row  = win_len() - 1;
        corner_col  = win_len() - 1;
        win_row_idx = 0;
        win_col_idx = 0;
    endtask

    task automatic apply_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_WINDOW: win_reg    = d[WS_REG_W-1:0];
            REG_STEP:   step_reg   = d[STEP_REG_W-1:0];
            REG_WIDTH:  width_reg  = d[DIM_REG_W-1:0];
            REG_HEIGHT: height_reg = d[DIM_REG_W-1:0];
            default:    ;
        endcase
        start_plane();
    endtask

    task automatic pool_step(input sample_t s);
        int ws;
        int st;
        int w;
        int h;
        int c0;
        int slot;
        int best_idx;
        sample_t best;
        sample_t v;
        pool_result_t r;
        ws = win_len();
        st = stride();
        w  = row_len();
        h  = plane_rows();
        if (in_col >= w)
            in_col = w - 1;
        line_buf[buf_slot * MAX_WIDTH + in_col] = s;

        if (in_row == corner_row && in_col == corner_col) begin
            c0       = in_col + 1 - ws;
            best     = '0;
            best_idx = -1;
            // row-major scan, strict compare keeps the first maximum
            for (int ph = 0; ph < ws; ph++) begin
                slot = (buf_slot + MAX_WINDOW - (ws - 1 - ph)) % MAX_WINDOW;
                for (int pw = 0; pw < ws; pw++) begin
                    v = line_buf[slot * MAX_WIDTH + c0 + pw];
                    if (best_idx < 0 || v > best) begin
                        best     = v;
                        best_idx = ph * ws + pw;
                    end
                end
            end
            r.max_value    = best;
            r.argmax_index = ARG_W'(best_idx);
            r.out_row      = OUT_POS_W'(win_row_idx);
            r.out_col      = OUT_POS_W'(win_col_idx);
            r.plane_done   = (corner_col + st >= w) && (corner_row + st >= h);
            expected_pool.push_back(r);
            corner_col  += st;
            win_col_idx++;
        end

        if (in_col + 1 >= w) begin
            in_col = 0;
            if (in_row == corner_row) begin
                corner_row += st;
                win_row_idx++;
            end
            corner_col  = ws - 1;
            win_col_idx = 0;
            in_row++;
            buf_slot = (buf_slot + 1) % MAX_WINDOW;
            if (in_row >= h)
                start_plane();
        end else begin
            in_col++;
        end
    endtask

    task automatic flag_mismatch(input string what, input int want_v, input int got_v);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("[%0t] mismatch on %s at pooled result %0d: expected %0d, got %0d",
                     $time, what, result_count, want_v, got_v);
    endtask

    task automatic check_result();
        pool_result_t want;
        if (expected_pool.size() == 0) begin
            flag_mismatch("beat with nothing expected", 0, int'(res.max_value));
        end else begin
            want = expected_pool.pop_front();
            if (res.max_value !== want.max_value)
                flag_mismatch("max_value", int'(want.max_value), int'(res.max_value));
            if (res.argmax_index !== want.argmax_index)
                flag_mismatch("argmax_index", int'(want.argmax_index), int'(res.argmax_index));
            if (res.out_row !== want.out_row)
                flag_mismatch("out_row", int'(want.out_row), int'(res.out_row));
            if (res.out_col !== want.out_col)
                flag_mismatch("out_col", int'(want.out_col), int'(res.out_col));
            if (res.plane_done !== want.plane_done)
                flag_mismatch("plane_done", int'(want.plane_done), int'(res.plane_done));
            if (want.plane_done)
                plane_count++;
            result_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            win_reg    = WS_REG_W'(2);
            step_reg   = STEP_REG_W'(2);
            width_reg  = DIM_REG_W'(28);
            height_reg = DIM_REG_W'(28);
            start_plane();
            expected_pool.delete();
            fail_count   = 0;
            pending      = 0;
            result_count = 0;
            plane_count  = 0;
        end else begin
            if (cfg.valid && cfg.ready)
                apply_write(cfg.index, cfg.data);
            if (pix.valid && pix.ready)
                pool_step(pix.sample);
            if (res.valid && res.ready)
                check_result();
            pending = expected_pool.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mp2a_pkg::*;

    localparam int RAND_ITEMS   = 120;
    localparam int DRAIN_CYCLES = MAX_WINDOW * MAX_WINDOW + 16;
    localparam int IDLE_LIMIT   = 4000;

    localparam sample_t SAMPLE_MAX = sample_t'(16'h7fff);
    localparam sample_t SAMPLE_MIN = sample_t'(16'h8000);

    // sample flavors for random planes
    localparam int MIX_FULL    = 0;
    localparam int MIX_TIES    = 1;
    localparam int MIX_EXTREME = 2;

    logic clk;
    logic rst_n;

    int fail_count;
    int pending;
    int result_count;
    int plane_count;
    int idle_cycles = 0;
    int samples_sent = 0;
    int reg_writes = 0;
    int burst_left = 0;
    int gap_max = 0;

    mp2a_pixel_if  pixel_bus ();
    mp2a_result_if result_bus ();
    mp2a_cfg_if    cfg_bus ();

    max_pool_2d_argmax u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    mp2a_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix          (pixel_bus),
        .res          (result_bus),
        .cfg          (cfg_bus),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count),
        .plane_count  (plane_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((pixel_bus.valid && pixel_bus.ready) || (result_bus.valid && result_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("watchdog: no handshake for %0d cycles, %0d results still expected",
                 IDLE_LIMIT, pending);
        $display("TEST FAILED");
        $finish;
    end

    // result side back-pressure, changes character after each random span
    initial
    begin
        int mode;
        int span;
        int hold;
        int period;
        int tick;
        result_bus.ready <= 1'b0;
        hold = 0;
        tick = 0;
        forever
        begin
            mode   = $urandom_range(0, 3);
            span   = $urandom_range(20, 200);
            period = $urandom_range(2, 4);
            repeat (span)
            begin
                @(posedge clk);
                tick++;
                case (mode)
                    0: result_bus.ready <= 1'b1;
                    1: result_bus.ready <= 1'($urandom_range(0, 1));
                    2:
                    begin
                        if (hold > 0)
                        begin
                            hold--;
                            result_bus.ready <= 1'b0;
                        end
                        else if ($urandom_range(0, 9) == 0)
                        begin
                            hold = $urandom_range(1, 12);
                            result_bus.ready <= 1'b0;
                        end
                        else
                            result_bus.ready <= 1'b1;
                    end
                    default: result_bus.ready <= ((tick % period) == 0);
                endcase
            end
        end
    end

    function automatic sample_t rand_sample(input int mix);
        sample_t v;
        case (mix)
            MIX_TIES: v = sample_t'(int'($urandom_range(0, 4)) - 2);
            MIX_EXTREME:
            begin
                case ($urandom_range(0, 3))
                    0:       v = SAMPLE_MIN;
                    1:       v = SAMPLE_MAX;
                    2:       v = '1;
                    default: v = '0;
                endcase
            end
            default: v = sample_t'($urandom);
        endcase
        return v;
    endfunction

    task automatic push_sample(input sample_t v);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (gap_max != 0)
            begin
                pixel_bus.valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
            end
        end
        pixel_bus.valid  <= 1'b1;
        pixel_bus.sample <= v;
        do
            @(posedge clk);
        while (!pixel_bus.ready);
        burst_left--;
        samples_sent++;
    endtask

    task automatic end_stream();
        pixel_bus.valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_drained();
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // extra wait after the last expected result has been checked
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input int value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        reg_writes++;
    endtask

    task automatic configure_pool(input int ws, input int st, input int w, input int h);
        wait_drained();
        write_reg(REG_WINDOW, ws);
        write_reg(REG_STEP, st);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic feed_random(input int count, input int mix);
        for (int i = 0; i < count; i++)
            push_sample(rand_sample(mix));
    endtask

    initial
    begin
        int ws_r;
        int st_r;
        int w_r;
        int h_r;
        int ws_e;
        int w_e;
        int h_e;
        int planes;
        int total;
        int mix;
        int rand_start;
        sample_t tie_grid [9];

        pixel_bus.valid  <= 1'b0;
        pixel_bus.sample <= '0;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= REG_WINDOW;
        cfg_bus.data     <= '0;
        rst_n            <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers as they come out of reset: 2x2 stride 2 on 28 wide rows
        gap_max = 3;
        feed_random(56, MIX_FULL);
        end_stream();

        // overlapping 2x2 windows, extremes and a tie on zero
        gap_max = 0;
        configure_pool(2, 1, 3, 3);
        tie_grid = '{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, sample_t'(-1),
                     sample_t'(0), sample_t'(0), SAMPLE_MAX};
        foreach (tie_grid[i])
            push_sample(tie_grid[i]);
        end_stream();

        // a window full of equal minimum values keeps index zero
        configure_pool(3, 3, 3, 3);
        for (int i = 0; i < 9; i++)
            push_sample(SAMPLE_MIN);
        end_stream();

        // zero window, zero step and zero height act as one
        configure_pool(0, 0, 3, 0);
        push_sample(sample_t'(16'h0100));
        push_sample(sample_t'(-1));
        push_sample(sample_t'(0));
        end_stream();

        // window larger than the plane gives nothing
        configure_pool(8, 1, 2, 2);
        feed_random(4, MIX_EXTREME);
        end_stream();

        // one row at the widest setting, register above the limit
        gap_max = 2;
        configure_pool(1, 1, 2047, 1);
        feed_random(MAX_WIDTH, MIX_FULL);
        end_stream();

        // top of a tall column under an oversize height, zero width acts as one
        configure_pool(1, 1, 0, 2047);
        feed_random(32, MIX_FULL);
        end_stream();

        // oversize window register clamps to 8: rising plane then falling plane
        configure_pool(15, 8, 16, 8);
        for (int i = 0; i < 128; i++)
            push_sample(sample_t'(i * 100 - 6400));
        for (int i = 0; i < 128; i++)
            push_sample(sample_t'(6400 - i * 100));
        end_stream();

        // largest in-range dimensions, plane cut short by the next write
        configure_pool(8, 8, 1024, 1024);
        feed_random(40, MIX_FULL);
        end_stream();

        rand_start = samples_sent;
        while (samples_sent - rand_start < RAND_ITEMS)
        begin
            case ($urandom_range(0, 7))
                0, 1, 2, 3, 4: ws_r = $urandom_range(1, 3);
                5, 6:          ws_r = $urandom_range(4, 8);
                default:       ws_r = $urandom_range(0, 15);
            endcase
            ws_e = (ws_r == 0) ? 1 : ((ws_r > MAX_WINDOW) ? MAX_WINDOW : ws_r);
            case ($urandom_range(0, 7))
                0, 1, 2, 3, 4: st_r = $urandom_range(1, ws_e);
                5, 6:          st_r = $urandom_range(1, 8);
                default:       st_r = $urandom_range(0, 15);
            endcase
            if ($urandom_range(0, 5) == 0)
                w_r = $urandom_range(0, ws_e);
            else
                w_r = ws_e + $urandom_range(0, 12);
            if ($urandom_range(0, 5) == 0)
                h_r = $urandom_range(0, ws_e);
            else
                h_r = ws_e + $urandom_range(0, 12);
            w_e = (w_r == 0) ? 1 : w_r;
            h_e = (h_r == 0) ? 1 : h_r;

            case ($urandom_range(0, 5))
                4:       mix = MIX_TIES;
                5:       mix = MIX_EXTREME;
                default: mix = MIX_FULL;
            endcase
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);

            planes = (w_e * h_e > 100) ? 1 : $urandom_range(1, 3);
            total  = planes * w_e * h_e;
            // now and then the plane is abandoned partway
            if ($urandom_range(0, 7) == 0)
                total = $urandom_range(1, total);
            // keep the random phase within its budget
            if (total > RAND_ITEMS - (samples_sent - rand_start))
                total = RAND_ITEMS - (samples_sent - rand_start);

            configure_pool(ws_r, st_r, w_r, h_r);
            feed_random(total, mix);
            end_stream();
        end

        wait_drained();

        $display("run covered %0d samples under %0d register writes, windows 1 to 8 wide,",
                 samples_sent, reg_writes);
        $display("rows up to 1024 samples across; %0d pooled results, %0d planes done",
                 result_count, plane_count);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
